// ----- hw/rtl/tlbl_pkg.sv -----
package tlbl_pkg;

    localparam int TLB_ENTRIES   = 10;
    localparam int SLOT_W        = 6;
    // Page-table depth is a power of two, so the modulo is a part-select.
    localparam int TABLE_ENTRIES = 4096;
    localparam int TBL_AW        = $clog2(TABLE_ENTRIES);

    localparam int PAGE_W  = 16;
    localparam int OFS_W   = 8;
    localparam int FRAME_W = 24;
    localparam int STAMP_W = 32;
    localparam int BASE_W  = 12;

    localparam logic [FRAME_W-1:0]        USER_BASE  = 24'h400000;
    localparam logic signed [STAMP_W-1:0] STAMP_TOP  = 32'sh7FFFFFFF;
    localparam logic signed [STAMP_W-1:0] STAMP_INIT = -32'sd1;

    localparam logic [0:0] KIND_XLATE = 1'b0;
    localparam logic [0:0] KIND_WRITE = 1'b1;

    localparam logic [0:0] REG_TABLE_BASE = 1'b0;

    typedef logic [SLOT_W-1:0] slot_t;

    // Search beat that walks down the row of cells.
    typedef struct packed {
        logic                        vld;
        logic [PAGE_W-1:0]           page;
        logic                        hit;
        slot_t                       hit_slot;
        logic [FRAME_W-1:0]          hit_frame;
        logic                        min_set;
        logic signed [STAMP_W-1:0]   min_stamp;
        slot_t                       min_slot;
    } token_t;

    // Update broadcast to all cells at the end of a translate.
    typedef struct packed {
        logic                        en;
        slot_t                       slot;
        logic                        fill;
        logic signed [STAMP_W-1:0]   stamp;
        logic [PAGE_W-1:0]           page;
        logic [FRAME_W-1:0]          frame;
    } upd_t;

endpackage

// ----- hw/rtl/tlbl_cell.sv -----
module tlbl_cell
    import tlbl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  slot_t  cell_idx,
    input  token_t tok_in,
    input  upd_t   upd,
    output token_t tok_out
);

    logic                      valid_reg;
    logic [PAGE_W-1:0]         page_reg;
    logic [FRAME_W-1:0]        frame_reg;
    logic signed [STAMP_W-1:0] stamp_reg;
    token_t                    tok_reg;
    token_t                    tok_next;
    logic                      upd_here;

    assign upd_here = upd.en && (upd.slot == cell_idx);

    always_comb
    begin
        tok_next = tok_in;
        // first valid match wins
        if (valid_reg && (page_reg == tok_in.page) && !tok_in.hit)
        begin
            tok_next.hit       = 1'b1;
            tok_next.hit_slot  = cell_idx;
            tok_next.hit_frame = frame_reg;
        end
        // strict less keeps the first index on ties
        if (!tok_in.min_set || (stamp_reg < tok_in.min_stamp))
        begin
            tok_next.min_set   = 1'b1;
            tok_next.min_stamp = stamp_reg;
            tok_next.min_slot  = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            page_reg  <= '0;
            frame_reg <= '0;
            stamp_reg <= STAMP_INIT;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (upd_here)
            begin
                stamp_reg <= upd.stamp;
                if (upd.fill)
                begin
                    valid_reg <= 1'b1;
                    page_reg  <= upd.page;
                    frame_reg <= upd.frame;
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hw/rtl/tlb_lru_translation.sv -----
// Fully associative TLB with LRU replacement by use stamps, backed by an on-chip
// page table. The TLB entries sit in a row of cells; a lookup beat walks the row
// one cell per cycle, collecting the first hit and the first least stamp, and the
// chosen entry is updated when the result moves to the output register. The time
// from one translate acceptance to the next is set by the walk through the cell
// row; a page-table write skips the row. After reset the page table is loaded
// with its reset contents, one entry per cycle, for all TABLE_ENTRIES (4096)
// entries; no beat is accepted during that pass, while the APB register stays
// writable. Only one item is in flight; the next is accepted while a finished
// result still waits in the output register.
module tlb_lru_translation
    import tlbl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // page[15:0], offset[23:16], entry_value[47:24]
    input  logic        s_tuser,  // kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // slot[5:0], phys_addr[29:6], zero[31:30]
    output logic        m_tuser   // hit
);

    logic [BASE_W-1:0]         table_base_reg;
    logic [TBL_AW:0]           clr_cnt_reg;
    logic                      clr_active;
    logic                      busy_reg;
    logic                      wr_pend_reg;
    logic [OFS_W-1:0]          offset_reg;
    token_t                    launch_reg;
    token_t                    fin_reg;
    logic                      fin_vld_reg;
    logic signed [STAMP_W-1:0] top_reg;
    logic signed [STAMP_W-1:0] stamp_next;
    logic [FRAME_W-1:0]        rd_data_reg;
    logic [FRAME_W-1:0]        mem [TABLE_ENTRIES];
    logic                      m_tvalid_reg;
    logic                      m_hit_reg;
    slot_t                     m_slot_reg;
    logic [FRAME_W-1:0]        m_phys_reg;

    logic                      s_accept;
    logic                      in_kind;
    logic [PAGE_W-1:0]         in_page;
    logic [OFS_W-1:0]          in_offset;
    logic [FRAME_W-1:0]        in_value;
    logic                      mem_we;
    logic [TBL_AW-1:0]         mem_waddr;
    logic [FRAME_W-1:0]        mem_wdata;
    logic                      rd_en;
    logic [TBL_AW-1:0]         rd_addr;
    logic                      res_go;
    slot_t                     res_slot;
    logic [FRAME_W-1:0]        res_frame;
    upd_t                      upd;
    token_t                    tok [TLB_ENTRIES+1];
    token_t                    launch_next;

    assign in_kind   = s_tuser;
    assign in_page   = s_tdata[15:0];
    assign in_offset = s_tdata[23:16];
    assign in_value  = s_tdata[47:24];

    // ---------------- APB register ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLE_BASE) ? {{(32-BASE_W){1'b0}}, table_base_reg}
                                                 : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_base_reg <= '0;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_BASE))
            table_base_reg <= pwdata[BASE_W-1:0];
    end

    // ---------------- page table ----------------
    assign clr_active = (clr_cnt_reg < (TBL_AW+1)'(TABLE_ENTRIES));
    assign s_tready   = !busy_reg && !clr_active;
    assign s_accept   = s_tvalid && s_tready;

    assign mem_we    = clr_active || (s_accept && (in_kind == KIND_WRITE));
    assign mem_waddr = clr_active ? clr_cnt_reg[TBL_AW-1:0] : in_page[TBL_AW-1:0];
    assign mem_wdata = clr_active
                     ? (USER_BASE + FRAME_W'({clr_cnt_reg[TBL_AW-1:0], 8'h00}))
                     : in_value;
    assign rd_en     = s_accept && (in_kind == KIND_XLATE);
    assign rd_addr   = TBL_AW'(table_base_reg) + in_page[TBL_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clr_active)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // ---------------- cell row ----------------
    always_comb
    begin
        launch_next      = '0;
        launch_next.vld  = rd_en;
        launch_next.page = in_page;
    end

    assign tok[0] = launch_reg;

    for (genvar k = 0; k < TLB_ENTRIES; k++)
    begin : g_cell
        tlbl_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (slot_t'(k)),
            .tok_in   (tok[k]),
            .upd      (upd),
            .tok_out  (tok[k+1])
        );
    end

    // ---------------- result and update ----------------
    assign stamp_next = (top_reg == STAMP_TOP) ? STAMP_TOP : top_reg + 32'sd1;
    assign res_go     = (fin_vld_reg || wr_pend_reg) && (!m_tvalid_reg || m_tready);
    assign res_slot   = fin_reg.hit ? fin_reg.hit_slot : fin_reg.min_slot;
    assign res_frame  = fin_reg.hit ? fin_reg.hit_frame : rd_data_reg;

    always_comb
    begin
        upd       = '0;
        upd.en    = res_go && fin_vld_reg;
        upd.slot  = res_slot;
        upd.fill  = !fin_reg.hit;
        upd.stamp = stamp_next;
        upd.page  = fin_reg.page;
        upd.frame = rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            wr_pend_reg  <= 1'b0;
            launch_reg   <= '0;
            fin_reg      <= '0;
            fin_vld_reg  <= 1'b0;
            top_reg      <= STAMP_INIT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= launch_next;
            if (s_accept)
            begin
                busy_reg <= 1'b1;
                if (in_kind == KIND_WRITE)
                    wr_pend_reg <= 1'b1;
            end
            // capture the beat leaving the row; hold it until the output frees up
            if (tok[TLB_ENTRIES].vld)
            begin
                fin_reg     <= tok[TLB_ENTRIES];
                fin_vld_reg <= 1'b1;
            end
            if (res_go)
            begin
                busy_reg     <= 1'b0;
                wr_pend_reg  <= 1'b0;
                fin_vld_reg  <= 1'b0;
                m_tvalid_reg <= 1'b1;
                if (fin_vld_reg)
                    top_reg <= stamp_next;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            offset_reg <= in_offset;
        if (res_go)
        begin
            if (wr_pend_reg)
            begin
                m_hit_reg  <= 1'b0;
                m_slot_reg <= '0;
                m_phys_reg <= '0;
            end
            else
            begin
                m_hit_reg  <= fin_reg.hit;
                m_slot_reg <= res_slot;
                m_phys_reg <= res_frame + {{(FRAME_W-OFS_W){1'b0}}, offset_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {2'b00, m_phys_reg, m_slot_reg};

    // ---------------- assertions ----------------
    assert property (@(posedge clk) disable iff (!rst_n) !busy_reg |-> !fin_vld_reg)
        else $error("finished lookup with no item in flight");

    assert property (@(posedge clk) disable iff (!rst_n) clr_active |-> !s_tready)
        else $error("input accepted during page-table load");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[5:0] < SLOT_W'(TLB_ENTRIES)))
        else $error("hit reported on a slot beyond the TLB");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_go && fin_vld_reg |=> (top_reg >= 32'sd0))
        else $error("stamp did not advance after a translate");

endmodule
